// ----- rtl/core/dll_pkg.sv -----
// shared constants, codes and types of the linked list engine
`timescale 1ns / 1ps
package dll_pkg;

	// node store size and derived widths
	localparam int CAPACITY     = 32;
	localparam int IDX_W        = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int RESULT_LIMIT = 32;
	localparam int DUMP_LIMIT   = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

	// field widths
	localparam int OP_W   = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND_BACK  = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
	localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd5;
	localparam logic [OP_W-1:0] OP_DUMP_BACK  = 3'd6;
	localparam logic [OP_W-1:0] OP_NONE       = 3'd7;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// one result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  pos;
		val_t              value;
		logic              last;
	} res_t;

	// write port of the value memory
	typedef struct packed {
		logic we;
		idx_t addr;
		val_t data;
	} val_wr_t;

	// write port of a link memory
	typedef struct packed {
		logic we;
		idx_t addr;
		idx_t data;
	} link_wr_t;

endpackage

// ----- rtl/core/dll_ram.sv -----
// generic single write, single read synchronous memory
`timescale 1ns / 1ps
module dll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/dll_ctrl.sv -----
// sequencer that walks the list and updates links and the free map
`timescale 1ns / 1ps
module dll_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [dll_pkg::OP_W-1:0] in_op,
	input  dll_pkg::val_t            in_key,
	input  dll_pkg::val_t            in_val,
	output dll_pkg::idx_t            rd_addr,
	input  dll_pkg::val_t            rd_val,
	input  dll_pkg::idx_t            rd_next,
	input  dll_pkg::idx_t            rd_prev,
	output dll_pkg::val_wr_t         val_wr,
	output dll_pkg::link_wr_t        next_wr,
	output dll_pkg::link_wr_t        prev_wr,
	output logic                     res_valid,
	input  logic                     res_ready,
	output dll_pkg::res_t            res
);
	import dll_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_DUMP = 3'd2;
	localparam logic [2:0] S_WR1  = 3'd3;
	localparam logic [2:0] S_WR2  = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	val_t                key_q;
	val_t                nval_q;
	idx_t                first_q;
	idx_t                last_q;
	cnt_t                count_q;
	logic [CAPACITY-1:0] free_q;
	idx_t                cur_q;
	idx_t                k_q;
	idx_t                node_q;
	idx_t                prev_q;
	idx_t                next_q;
	idx_t                alloc_q;
	logic                empty_q;
	res_t                res_q;

	idx_t start_idx;
	idx_t free_idx;
	idx_t walk_link;
	idx_t dump_link;
	cnt_t k_next;
	logic match;
	logic walk_end;
	logic dump_last;

	// lowest free node
	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// walk decisions on the node whose data is arriving
	assign start_idx = (in_op == OP_FIND_BACK || in_op == OP_DUMP_BACK) ? last_q : first_q;
	assign walk_link = (op_q == OP_FIND_BACK) ? rd_prev : rd_next;
	assign dump_link = (op_q == OP_DUMP_BACK) ? rd_prev : rd_next;
	assign k_next    = cnt_t'(k_q) + 1'b1;
	assign match     = (rd_val == key_q);
	assign walk_end  = (k_next == count_q);
	assign dump_last = (k_next == count_q) || (k_next == CNT_W'(DUMP_LIMIT));

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP) || (state_q == S_DUMP);

	// result beat: dump streams straight from the memory read
	always_comb begin
		if (state_q == S_DUMP) begin
			res.status = STAT_OK;
			res.pos    = POS_W'(k_q);
			res.value  = rd_val;
			res.last   = dump_last;
		end else begin
			res = res_q;
		end
	end

	// read address and memory writes
	always_comb begin
		rd_addr = cur_q;
		val_wr  = '0;
		next_wr = '0;
		prev_wr = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = start_idx;
			end
			S_WALK: begin
				if (!match && !walk_end) begin
					rd_addr = walk_link;
				end
			end
			S_DUMP: begin
				if (res_ready && !dump_last) begin
					rd_addr = dump_link;
				end
			end
			S_WR1: begin
				if (empty_q) begin
					val_wr  = '{we: 1'b1, addr: free_idx, data: nval_q};
					next_wr = '{we: 1'b1, addr: free_idx, data: free_idx};
					prev_wr = '{we: 1'b1, addr: free_idx, data: free_idx};
				end else if (op_q == OP_INS_BEFORE) begin
					val_wr  = '{we: 1'b1, addr: free_idx, data: nval_q};
					next_wr = '{we: 1'b1, addr: free_idx, data: node_q};
					prev_wr = '{we: 1'b1, addr: free_idx, data: prev_q};
				end else if (op_q == OP_INS_AFTER) begin
					val_wr  = '{we: 1'b1, addr: free_idx, data: nval_q};
					prev_wr = '{we: 1'b1, addr: free_idx, data: node_q};
					next_wr = '{we: 1'b1, addr: free_idx, data: next_q};
				end else begin
					next_wr = '{we: (node_q != first_q), addr: prev_q, data: next_q};
					prev_wr = '{we: (node_q != last_q), addr: next_q, data: prev_q};
				end
			end
			S_WR2: begin
				if (op_q == OP_INS_BEFORE) begin
					next_wr = '{we: (node_q != first_q), addr: prev_q, data: alloc_q};
					prev_wr = '{we: 1'b1, addr: node_q, data: alloc_q};
				end else begin
					prev_wr = '{we: (node_q != last_q), addr: next_q, data: alloc_q};
					next_wr = '{we: 1'b1, addr: node_q, data: alloc_q};
				end
			end
			S_RESP: begin
				rd_addr = cur_q;
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			key_q   <= '0;
			nval_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
			count_q <= '0;
			free_q  <= '1;
			cur_q   <= '0;
			k_q     <= '0;
			node_q  <= '0;
			prev_q  <= '0;
			next_q  <= '0;
			alloc_q <= '0;
			empty_q <= 1'b0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_op;
						key_q   <= in_key;
						nval_q  <= in_val;
						cur_q   <= start_idx;
						k_q     <= '0;
						empty_q <= 1'b0;
						if (in_op == OP_NONE) begin
							state_q <= S_IDLE;
						end else if (in_op == OP_INS_BEFORE || in_op == OP_INS_AFTER) begin
							if (count_q == cnt_t'(CAPACITY)) begin
								res_q   <= '{status: STAT_FULL, pos: '0, value: '0, last: 1'b1};
								state_q <= S_RESP;
							end else if (count_q == '0) begin
								if (in_op == OP_INS_BEFORE) begin
									res_q   <= '{status: STAT_NOT_FOUND, pos: '0, value: '0,
										last: 1'b1};
									state_q <= S_RESP;
								end else begin
									empty_q <= 1'b1;
									state_q <= S_WR1;
								end
							end else begin
								state_q <= S_WALK;
							end
						end else if (count_q == '0) begin
							res_q   <= '{status: STAT_EMPTY, pos: '0, value: '0, last: 1'b1};
							state_q <= S_RESP;
						end else if (in_op == OP_DUMP_FWD || in_op == OP_DUMP_BACK) begin
							state_q <= S_DUMP;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (match) begin
						node_q <= cur_q;
						prev_q <= rd_prev;
						next_q <= rd_next;
						if (op_q == OP_FIND_FRONT || op_q == OP_FIND_BACK) begin
							res_q   <= '{status: STAT_OK, pos: POS_W'(k_q), value: key_q,
								last: 1'b1};
							state_q <= S_RESP;
						end else begin
							state_q <= S_WR1;
						end
					end else if (walk_end) begin
						res_q   <= '{status: STAT_NOT_FOUND, pos: '0, value: '0, last: 1'b1};
						state_q <= S_RESP;
					end else begin
						cur_q <= walk_link;
						k_q   <= k_q + 1'b1;
					end
				end
				S_DUMP: begin
					if (res_ready) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							cur_q <= dump_link;
							k_q   <= k_q + 1'b1;
						end
					end
				end
				S_WR1: begin
					if (empty_q) begin
						free_q[free_idx] <= 1'b0;
						first_q <= free_idx;
						last_q  <= free_idx;
						count_q <= cnt_t'(1);
						res_q   <= '{status: STAT_OK, pos: '0, value: nval_q, last: 1'b1};
						state_q <= S_RESP;
					end else if (op_q == OP_REMOVE) begin
						free_q[node_q] <= 1'b1;
						count_q <= count_q - 1'b1;
						if (count_q == cnt_t'(1)) begin
							first_q <= '0;
							last_q  <= '0;
						end else begin
							if (node_q == first_q) begin
								first_q <= next_q;
							end
							if (node_q == last_q) begin
								last_q <= prev_q;
							end
						end
						res_q   <= '{status: STAT_OK, pos: POS_W'(k_q), value: key_q, last: 1'b1};
						state_q <= S_RESP;
					end else begin
						free_q[free_idx] <= 1'b0;
						alloc_q <= free_idx;
						state_q <= S_WR2;
					end
				end
				S_WR2: begin
					count_q <= count_q + 1'b1;
					if (op_q == OP_INS_BEFORE) begin
						if (node_q == first_q) begin
							first_q <= alloc_q;
						end
						res_q <= '{status: STAT_OK, pos: POS_W'(k_q), value: nval_q, last: 1'b1};
					end else begin
						if (node_q == last_q) begin
							last_q <= alloc_q;
						end
						res_q <= '{status: STAT_OK, pos: POS_W'(k_q) + 1'b1, value: nval_q,
							last: 1'b1};
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/doubly_linked_list_engine_core.sv -----
// Doubly linked list engine of signed 32-bit values in a fixed node store.
// Input channel s_*: one beat is one operation, the code in s_tuser,
// the key and the new value in s_tdata. Output channel m_*: result beats
// with status in m_tuser, position and value in m_tdata, m_tlast on the
// final beat of an operation; a dump gives one beat per node (one status
// beat on an empty list), every other operation one beat, the unused code none.
// Node values and both links sit in three memories with registered read
// ports that are read at one address per cycle; the sequencer follows the
// links, so a search visits one node per clock, at most 32 per operation;
// s_tready is high only while no operation is in progress.
// A dump streams from the memory read, one beat per cycle while m_tready
// holds; a stalled receiver holds the walk. The output register takes a
// result only when it is empty or drains in the same cycle.
// Reset empties the list and marks every node free at once; no clearing
// pass is needed, node memory is read only through the live links.
`timescale 1ns / 1ps
module doubly_linked_list_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // match_key[31:0], new_value[63:32]
	input  logic [2:0]  s_tuser,  // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // position[4:0], item_value[36:5], zero pad
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast   // last_of_run
);
	import dll_pkg::*;

	idx_t     rd_addr;
	val_t     rd_val;
	idx_t     rd_next;
	idx_t     rd_prev;
	val_wr_t  val_wr;
	link_wr_t next_wr;
	link_wr_t prev_wr;
	logic     res_valid;
	logic     res_ready;
	res_t     res;
	logic     out_valid_q;
	res_t     out_q;

	// node memories
	dll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_wr.we),
		.waddr (val_wr.addr),
		.wdata (val_wr.data),
		.raddr (rd_addr),
		.rdata (rd_val)
	);

	dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (next_wr.we),
		.waddr (next_wr.addr),
		.wdata (next_wr.data),
		.raddr (rd_addr),
		.rdata (rd_next)
	);

	dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
		.clk   (clk),
		.we    (prev_wr.we),
		.waddr (prev_wr.addr),
		.wdata (prev_wr.data),
		.raddr (rd_addr),
		.rdata (rd_prev)
	);

	// sequencer
	dll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_key    (s_tdata[31:0]),
		.in_val    (s_tdata[63:32]),
		.rd_addr   (rd_addr),
		.rd_val    (rd_val),
		.rd_next   (rd_next),
		.rd_prev   (rd_prev),
		.val_wr    (val_wr),
		.next_wr   (next_wr),
		.prev_wr   (prev_wr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, refilled in the cycle it drains
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.value, out_q.pos};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule
